/* src/blp_pkg.sv */
// Shared constants, types and word layouts for the Bresenham line pixel engine.
package blp_pkg;

   localparam int COORD_BITS = 10;
   localparam int COLOR_BITS = 16;
   localparam int CNT_BITS   = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 3;

   // stream word widths, rounded up to whole bytes
   localparam int REQ_FIELD_BITS = 4 * COORD_BITS + COLOR_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [ERR_BITS-1:0] err_type;

   // decoded command passed from front to back
   typedef struct packed {
      logic                  is_load;
      coord_type             x_start;
      coord_type             y_start;
      logic                  x_negative;
      logic                  y_negative;
      logic                  x_is_major;
      err_type               err_init;
      err_type               inc_minor;   // error delta when only the major axis steps
      err_type               inc_both;    // error delta when both axes step
      logic [CNT_BITS-1:0]   pixel_count;
      logic [COLOR_BITS-1:0] color;
   } op_type;

endpackage

/* src/blp_front.sv */
// Front end: accepts request words and decodes loads into line setup values.
module blp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [blp_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic [0:0]                         req_tuser,
   output logic                               op_valid,
   input  logic                               op_ready,
   output blp_pkg::op_type                    op_data
);
   import blp_pkg::*;

   logic      valid_ff, valid_in;
   op_type    op_ff, op_in;
   logic      accept;
   coord_type xs, ys, xe, ye, dx, dy, major, minor;
   logic      x_neg, y_neg, x_major;

   assign xs = req_tdata[COORD_BITS-1:0];
   assign ys = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign xe = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign ye = req_tdata[4*COORD_BITS-1:3*COORD_BITS];

   assign req_tready = !reset && (!valid_ff || op_ready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      x_neg   = xe < xs;
      y_neg   = ye < ys;
      dx      = x_neg ? xs - xe : xe - xs;
      dy      = y_neg ? ys - ye : ye - ys;
      x_major = dx > dy;
      major   = x_major ? dx : dy;
      minor   = x_major ? dy : dx;

      op_in.is_load     = (cmd_type'(req_tuser) == CMD_LOAD);
      op_in.x_start     = xs;
      op_in.y_start     = ys;
      op_in.x_negative  = x_neg;
      op_in.y_negative  = y_neg;
      op_in.x_is_major  = x_major;
      op_in.err_init    = (ERR_BITS'(minor) <<< 1) - ERR_BITS'(major);
      op_in.inc_minor   = ERR_BITS'(minor) <<< 1;
      op_in.inc_both    = (ERR_BITS'(minor) <<< 1) - (ERR_BITS'(major) <<< 1);
      op_in.pixel_count = CNT_BITS'(major) + CNT_BITS'(1);
      op_in.color       = req_tdata[REQ_FIELD_BITS-1:4*COORD_BITS];
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (op_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_in;
      end
   end

   assign op_valid = valid_ff;
   assign op_data  = op_ff;

endmodule

/* src/blp_queue.sv */
// Short FIFO of decoded commands between front and back.
module blp_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  blp_pkg::op_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output blp_pkg::op_type out_data
);
   import blp_pkg::*;

   op_type                    mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      push, pop;

   assign in_ready  = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_data;
      end
   end

endmodule

/* src/blp_back.sv */
// Back end: holds the active line, steps the error term and registers each pixel.
module blp_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               op_valid,
   output logic                               op_ready,
   input  blp_pkg::op_type                    op_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [blp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import blp_pkg::*;

   logic                  active_ff, active_in;
   coord_type             cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   err_type               err_ff, err_in;
   err_type               inc_minor_ff, inc_both_ff;
   logic [CNT_BITS-1:0]   left_ff, left_in;
   logic                  x_neg_ff, y_neg_ff, x_major_ff;
   logic [COLOR_BITS-1:0] color_ff;

   logic                  out_valid_ff, out_valid_in;
   coord_type             out_x_ff, out_y_ff;
   logic [COLOR_BITS-1:0] out_color_ff;
   logic                  out_last_ff;

   logic out_free, pop, do_load, do_pixel, err_ge, step_x, step_y;

   assign out_free = !out_valid_ff || rsp_tready;
   assign op_ready = op_data.is_load || !active_ff || out_free;
   assign pop      = op_valid && op_ready;
   assign do_load  = pop && op_data.is_load;
   assign do_pixel = pop && !op_data.is_load && active_ff;

   assign err_ge = !err_ff[ERR_BITS-1];
   assign step_x = x_major_ff || err_ge;
   assign step_y = !x_major_ff || err_ge;

   always_comb begin
      active_in = active_ff;
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      err_in    = err_ff;
      left_in   = left_ff;
      if (do_load) begin
         active_in = 1'b1;
         cur_x_in  = op_data.x_start;
         cur_y_in  = op_data.y_start;
         err_in    = op_data.err_init;
         left_in   = op_data.pixel_count;
      end else if (do_pixel) begin
         if (step_x) begin
            cur_x_in = x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
         end
         if (step_y) begin
            cur_y_in = y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
         end
         err_in    = err_ff + (err_ge ? inc_both_ff : inc_minor_ff);
         left_in   = left_ff - 1'b1;
         active_in = (left_ff != CNT_BITS'(1));
      end
   end

   always_comb begin
      if (do_pixel) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      err_ff   <= err_in;
      left_ff  <= left_in;
      if (do_load) begin
         inc_minor_ff <= op_data.inc_minor;
         inc_both_ff  <= op_data.inc_both;
         x_neg_ff     <= op_data.x_negative;
         y_neg_ff     <= op_data.y_negative;
         x_major_ff   <= op_data.x_is_major;
         color_ff     <= op_data.color;
      end
      if (do_pixel) begin
         out_x_ff     <= cur_x_ff;
         out_y_ff     <= cur_y_ff;
         out_color_ff <= color_ff;
         out_last_ff  <= (left_ff == CNT_BITS'(1));
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - RSP_FIELD_BITS){1'b0}},
                        out_color_ff, out_y_ff, out_x_ff};

endmodule

/* src/bresenham_line_pixels.sv */
// Top level of the Bresenham line pixel engine.
//
// Request channel (req_*): each word is a command in req_tuser. A load word
// (CMD_LOAD) carries both endpoints and the color and replaces any active
// line; it yields no pixel. A step word (CMD_STEP) yields the next pixel of
// the active line, or nothing when no line is active.
// Response channel (rsp_*): one word per pixel, x, y and color in rsp_tdata,
// rsp_tlast set on the line's final endpoint.
// A step word passes the decode register, the two-entry queue and the pixel
// register before its pixel shows on rsp.
// Throughput: one word per cycle in each direction while rsp_tready is high;
// the error update is one add and one sign test per pixel in the back end.
// Reset clears the active line, the queue and all valid flags; req_tready is
// low while reset is high.
// When rsp_tready is low the pixel register holds, the back end stops on the
// next step word of an active line, and the queue plus decode register hold
// up to three request words, the stopped step word included, before req_tready
// drops. Load words keep draining meanwhile only if they reach the queue head.
module bresenham_line_pixels (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [9:0] x_start, [19:10] y_start, [29:20] x_end, [39:30] y_end, [55:40] line_color
   input  logic [blp_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // [0] command
   input  logic [0:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [9:0] pixel_x, [19:10] pixel_y, [35:20] pixel_color, [39:36] zero
   output logic [blp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import blp_pkg::*;

   logic   f_valid, f_ready, b_valid, b_ready;
   op_type f_data, b_data;

   blp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .op_valid   (f_valid),
      .op_ready   (f_ready),
      .op_data    (f_data)
   );

   blp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   blp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (b_valid),
      .op_ready   (b_ready),
      .op_data    (b_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/blp_checker.sv */
// Port-level checks for the Bresenham line pixel engine, bound to the top level.
module blp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [0:0]                         req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [blp_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                               rsp_tlast
);
   import blp_pkg::*;

   logic no_load;

   // cycle without an accepted load word
   assign no_load = !(req_tvalid && req_tready) || (cmd_type'(req_tuser) == CMD_STEP);

   // stalled pixel word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // no pixel until a word has passed the decode register, queue and pixel register after reset
   a_reset_latency: assert property (@(posedge clock)
      reset |=> !rsp_tvalid ##1 !rsp_tvalid ##1 !rsp_tvalid)
      else $error("pixel too soon after reset");

   // steps with no line loaded since reset give no pixel
   a_no_line_no_pixel: assert property (@(posedge clock)
      reset ##1 no_load ##1 no_load ##1 no_load ##1 no_load |-> !rsp_tvalid)
      else $error("pixel without a loaded line");

endmodule

bind bresenham_line_pixels blp_checker u_blp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
